[hdl/epdc_pkg.sv]
// package: shared types, constants and calendar helpers for the epoch-to-date converter
`timescale 1ns / 1ps

package epdc_pkg;

  // divisors of the time-of-day split, each taken after its power-of-two factor is
  // shifted off; reciprocals are floor(2^32 / divisor), so the quotient estimate
  // is at most one low for any dividend below 2^32
  localparam logic [9:0]  DAY_DIV    = 10'd675;
  localparam logic [29:0] DAY_RECIP  = 30'd6362914;
  localparam logic [9:0]  HOUR_DIV   = 10'd225;
  localparam logic [29:0] HOUR_RECIP = 30'd19088743;
  localparam logic [9:0]  MIN_DIV    = 10'd15;
  localparam logic [29:0] MIN_RECIP  = 30'd286331153;
  localparam logic [9:0]  WEEK_DIV   = 10'd7;
  localparam logic [29:0] WEEK_RECIP = 30'd613566756;

  // calendar constants, years kept as offset from 1900
  localparam logic [7:0] EPOCH_YEAR_OFS     = 8'd70;
  localparam logic [7:0] NONLEAP_CENTURY    = 8'd200;
  localparam logic [8:0] YEAR_DAYS          = 9'd365;
  localparam logic [8:0] LEAP_YEAR_DAYS     = 9'd366;
  localparam logic [3:0] MONTH_JAN          = 4'd0;
  localparam logic [3:0] MONTH_DEC          = 4'd11;
  localparam logic [3:0] EPOCH_WEEKDAY      = 4'd4;

  // default depth of the queue between front and back
  localparam int FIFO_DEPTH_DEFAULT = 2;

  // item handed from front to back
  typedef struct packed {
    logic [15:0] days;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [2:0]  weekday;
  } epdc_item_t;

  // finished result, first field in the highest bits
  typedef struct packed {
    logic [8:0] day_of_year;
    logic [2:0] weekday;
    logic [7:0] years_since_1900;
    logic [3:0] month_index;
    logic [4:0] day_of_month;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
  } epdc_result_t;

  typedef enum logic [2:0] {
    F_IDLE,
    F_MUL,
    F_REM,
    F_FIX,
    F_PUSH
  } epdc_front_state_t;

  // which constant division the front end is working on
  typedef enum logic [1:0] {
    DIV_DAY,
    DIV_HOUR,
    DIV_MIN,
    DIV_WEEK
  } epdc_div_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_YEAR,
    B_MONTH,
    B_DONE
  } epdc_back_state_t;

  // gregorian leap test for 1900 + yr over the reachable span 1970..2106
  function automatic logic is_leap(input logic [7:0] yr);
    return (yr[1:0] == 2'b00) && (yr != NONLEAP_CENTURY);
  endfunction

  // month length table, month 0 is january
  function automatic logic [4:0] days_in_month(input logic leap, input logic [3:0] mon);
    logic [4:0] len;
    unique case (mon)
      4'd0:    len = 5'd31;
      4'd1:    len = leap ? 5'd29 : 5'd28;
      4'd2:    len = 5'd31;
      4'd3:    len = 5'd30;
      4'd4:    len = 5'd31;
      4'd5:    len = 5'd30;
      4'd6:    len = 5'd31;
      4'd7:    len = 5'd31;
      4'd8:    len = 5'd30;
      4'd9:    len = 5'd31;
      4'd10:   len = 5'd30;
      4'd11:   len = 5'd31;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

[hdl/epdc_front.sv]
// front end: accepts seconds and splits them into days, hour, minute, second and weekday
`timescale 1ns / 1ps

module epdc_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [31:0]        in_tdata,   // epoch_seconds[31:0]
  output logic               q_push,
  output epdc_pkg::epdc_item_t q_item,
  input  logic               q_full
);
  import epdc_pkg::*;

  epdc_front_state_t state_r, state_nxt;
  epdc_div_t   phase_r, phase_nxt;
  logic [24:0] num_r, num_nxt;
  logic [6:0]  lo_r, lo_nxt;
  logic [15:0] q_r, q_nxt;
  logic [10:0] rem_r, rem_nxt;
  logic [15:0] days_r, days_nxt;
  logic [4:0]  hour_r, hour_nxt;
  logic [5:0]  minute_r, minute_nxt;
  logic [5:0]  second_r, second_nxt;
  logic [2:0]  wk_r, wk_nxt;

  logic [9:0]  div_c;
  logic [29:0] recip_c;
  logic [54:0] prod;
  logic [25:0] q_times_div;
  logic [25:0] rem_full;
  logic        rem_ge;
  logic [15:0] q_fix;
  logic [9:0]  r_fix;

  // divisor and reciprocal of the current division
  always_comb begin
    unique case (phase_r)
      DIV_DAY: begin
        div_c   = DAY_DIV;
        recip_c = DAY_RECIP;
      end
      DIV_HOUR: begin
        div_c   = HOUR_DIV;
        recip_c = HOUR_RECIP;
      end
      DIV_MIN: begin
        div_c   = MIN_DIV;
        recip_c = MIN_RECIP;
      end
      DIV_WEEK: begin
        div_c   = WEEK_DIV;
        recip_c = WEEK_RECIP;
      end
    endcase
  end

  // reciprocal estimate, remainder, and one-step correction
  always_comb begin
    prod        = {30'd0, num_r} * {25'd0, recip_c};
    q_times_div = {10'd0, q_r} * {16'd0, div_c};
    rem_full    = {1'b0, num_r} - q_times_div;
    rem_ge      = (rem_r >= {1'b0, div_c});
    q_fix       = rem_ge ? q_r + 16'd1 : q_r;
    r_fix       = rem_ge ? 10'(rem_r - {1'b0, div_c}) : rem_r[9:0];
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      F_IDLE:  if (in_tvalid) state_nxt = F_MUL;
      F_MUL:   state_nxt = F_REM;
      F_REM:   state_nxt = F_FIX;
      F_FIX:   state_nxt = (phase_r == DIV_WEEK) ? F_PUSH : F_MUL;
      F_PUSH:  if (!q_full) state_nxt = F_IDLE;
      default: state_nxt = F_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    in_tready = (state_r == F_IDLE);
    q_push    = (state_r == F_PUSH) && !q_full;
  end

  // datapath next values
  always_comb begin
    phase_nxt  = phase_r;
    num_nxt    = num_r;
    lo_nxt     = lo_r;
    q_nxt      = q_r;
    rem_nxt    = rem_r;
    days_nxt   = days_r;
    hour_nxt   = hour_r;
    minute_nxt = minute_r;
    second_nxt = second_r;
    wk_nxt     = wk_r;
    unique case (state_r)
      F_IDLE: begin
        phase_nxt = DIV_DAY;
        num_nxt   = in_tdata[31:7];
        lo_nxt    = in_tdata[6:0];
      end
      F_MUL: begin
        q_nxt = prod[47:32];
      end
      F_REM: begin
        rem_nxt = rem_full[10:0];
      end
      F_FIX: begin
        unique case (phase_r)
          DIV_DAY: begin
            // time of day shifted right by four feeds the hour split
            days_nxt  = q_fix;
            num_nxt   = {12'd0, r_fix, lo_r[6:4]};
            lo_nxt    = {3'd0, lo_r[3:0]};
            phase_nxt = DIV_HOUR;
          end
          DIV_HOUR: begin
            // seconds within the hour shifted right by two feed the minute split
            hour_nxt  = q_fix[4:0];
            num_nxt   = {15'd0, r_fix[7:0], lo_r[3:2]};
            lo_nxt    = {5'd0, lo_r[1:0]};
            phase_nxt = DIV_MIN;
          end
          DIV_MIN: begin
            minute_nxt = q_fix[5:0];
            second_nxt = {r_fix[3:0], lo_r[1:0]};
            num_nxt    = {9'd0, days_r} + {21'd0, EPOCH_WEEKDAY};
            phase_nxt  = DIV_WEEK;
          end
          DIV_WEEK: begin
            wk_nxt = r_fix[2:0];
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  // queue payload
  always_comb begin
    q_item.days    = days_r;
    q_item.hour    = hour_r;
    q_item.minute  = minute_r;
    q_item.second  = second_r;
    q_item.weekday = wk_r;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    phase_r  <= phase_nxt;
    num_r    <= num_nxt;
    lo_r     <= lo_nxt;
    q_r      <= q_nxt;
    rem_r    <= rem_nxt;
    days_r   <= days_nxt;
    hour_r   <= hour_nxt;
    minute_r <= minute_nxt;
    second_r <= second_nxt;
    wk_r     <= wk_nxt;
  end

endmodule

[hdl/epdc_fifo.sv]
// small queue of split-up items between front and back
`timescale 1ns / 1ps

module epdc_fifo #(
  parameter int DEPTH = epdc_pkg::FIFO_DEPTH_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  epdc_pkg::epdc_item_t push_item,
  output logic                 full,
  input  logic                 pop,
  output epdc_pkg::epdc_item_t pop_item,
  output logic                 empty
);
  import epdc_pkg::*;

  localparam int PtrW = $clog2(DEPTH);
  localparam int CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  epdc_item_t          mem_r [DEPTH];
  logic [PtrW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0]     cnt_r, cnt_nxt;
  logic                do_push, do_pop;

  // status and read side
  always_comb begin
    full     = (cnt_r == FullCnt);
    empty    = (cnt_r == '0);
    do_push  = push && !full;
    do_pop   = pop && !empty;
    pop_item = mem_r[rd_ptr_r];
  end

  // pointer and count updates
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) wr_ptr_nxt = (wr_ptr_r == LastPtr) ? '0 : wr_ptr_r + 1'b1;
    if (do_pop)  rd_ptr_nxt = (rd_ptr_r == LastPtr) ? '0 : rd_ptr_r + 1'b1;
    if (do_push && !do_pop)      cnt_nxt = cnt_r + 1'b1;
    else if (do_pop && !do_push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_item;
  end

endmodule

[hdl/epdc_back.sv]
// back end: walks years and months off the day count and holds the result beat
`timescale 1ns / 1ps

module epdc_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_empty,
  output logic                 q_pop,
  input  epdc_pkg::epdc_item_t q_item,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [47:0]          out_tdata
);
  import epdc_pkg::*;

  epdc_back_state_t state_r, state_nxt;
  epdc_item_t   item_r, item_nxt;
  logic [15:0]  days_r, days_nxt;
  logic [7:0]   yr_r, yr_nxt;
  logic [3:0]   mon_r, mon_nxt;
  logic [8:0]   yday_r, yday_nxt;
  epdc_result_t res_r, res_nxt;
  logic         out_valid_r, out_valid_nxt;

  logic         leap;
  logic [8:0]   year_len;
  logic [4:0]   month_len;
  logic         year_fits;
  logic         month_fits;
  logic         load_out;

  // year and month length of the current step
  always_comb begin
    leap       = is_leap(yr_r);
    year_len   = leap ? LEAP_YEAR_DAYS : YEAR_DAYS;
    month_len  = days_in_month(leap, mon_r);
    year_fits  = (days_r >= {7'd0, year_len});
    month_fits = (mon_r != MONTH_DEC) && (days_r >= {11'd0, month_len});
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE:  if (!q_empty) state_nxt = B_YEAR;
      B_YEAR:  if (!year_fits) state_nxt = B_MONTH;
      B_MONTH: if (!month_fits) state_nxt = B_DONE;
      B_DONE:  if (!out_valid_r || out_tready) state_nxt = B_IDLE;
      default: state_nxt = B_IDLE;
    endcase
  end

  // queue and output register control
  always_comb begin
    q_pop    = (state_r == B_IDLE) && !q_empty;
    load_out = (state_r == B_DONE) && (!out_valid_r || out_tready);
    if (load_out)        out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
    else                 out_valid_nxt = out_valid_r;
  end

  // datapath next values
  always_comb begin
    item_nxt = item_r;
    days_nxt = days_r;
    yr_nxt   = yr_r;
    mon_nxt  = mon_r;
    yday_nxt = yday_r;
    res_nxt  = res_r;
    unique case (state_r)
      B_IDLE: begin
        item_nxt = q_item;
        days_nxt = q_item.days;
        yr_nxt   = EPOCH_YEAR_OFS;
        mon_nxt  = MONTH_JAN;
      end
      B_YEAR: begin
        if (year_fits) begin
          days_nxt = days_r - {7'd0, year_len};
          yr_nxt   = yr_r + 8'd1;
        end else begin
          yday_nxt = days_r[8:0];
        end
      end
      B_MONTH: begin
        if (month_fits) begin
          days_nxt = days_r - {11'd0, month_len};
          mon_nxt  = mon_r + 4'd1;
        end
      end
      B_DONE: begin
        if (load_out) begin
          res_nxt.second           = item_r.second;
          res_nxt.minute           = item_r.minute;
          res_nxt.hour             = item_r.hour;
          res_nxt.day_of_month     = days_r[4:0] + 5'd1;
          res_nxt.month_index      = mon_r;
          res_nxt.years_since_1900 = yr_r;
          res_nxt.weekday          = item_r.weekday;
          res_nxt.day_of_year      = yday_r;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, res_r};

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    days_r <= days_nxt;
    yr_r   <= yr_nxt;
    mon_r  <= mon_nxt;
    yday_r <= yday_nxt;
    res_r  <= res_nxt;
  end

endmodule

[hdl/epoch_seconds_to_calendar_date_top.sv]
// top level: unsigned epoch seconds in, broken-down utc date and time out
`timescale 1ns / 1ps

// Converts a 32-bit unsigned count of seconds since 1970-01-01 00:00:00 UTC into
// second, minute, hour, day of month, month (0 is January), year since 1900,
// weekday (0 is Sunday) and day of year, using Gregorian leap years. One input
// beat gives exactly one output beat, in order. The front end takes one beat at a
// time: after accepting it, four divisions by a constant (day count, hour, minute,
// weekday) each take a reciprocal multiply, a remainder and a one-step correction,
// and the split-up item is then pushed. A queue of FIFO_DEPTH entries feeds the
// back end, which removes one whole year per cycle from 1970 on and then one month
// per cycle, so its time per beat grows with the years since 1970 and the month
// index; the slower of the front end and that walk sets the sustained rate. The
// finished result waits in an output register while the next beat is worked on.

module epoch_seconds_to_calendar_date_top #(
  parameter int FIFO_DEPTH = epdc_pkg::FIFO_DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // epoch_seconds[31:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata   // second[5:0], minute[11:6], hour[16:12],
                                  // day_of_month[21:17], month_index[25:22],
                                  // years_since_1900[33:26], weekday[36:34],
                                  // day_of_year[45:37], zero[47:46]
);
  import epdc_pkg::*;

  logic       q_push;
  logic       q_full;
  logic       q_pop;
  logic       q_empty;
  epdc_item_t q_wr_item;
  epdc_item_t q_rd_item;

  // split seconds into day count, time of day and weekday
  epdc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_push    (q_push),
    .q_item    (q_wr_item),
    .q_full    (q_full)
  );

  // decoupling queue
  epdc_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_wr_item),
    .full      (q_full),
    .pop       (q_pop),
    .pop_item  (q_rd_item),
    .empty     (q_empty)
  );

  // year and month walk, output register
  epdc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .q_item     (q_rd_item),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

[verif/epoch_seconds_to_calendar_date_top_test.sv]
`timescale 1ns / 1ps
// testbench: epoch seconds to calendar date converter checked against a behavioral date model

module epoch_seconds_to_calendar_date_top_test;
  import epdc_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 1500000;
  localparam int          DRAIN_CYCLES = 200;
  localparam int unsigned SECS_PER_DAY = 86400;
  // last day index whose final second still fits in 32 bits
  localparam int unsigned LAST_FULL_DAY = 49709;
  localparam int unsigned MONTH_LEN [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata   = '0;    // epoch_seconds[31:0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;          // second, minute, hour, day_of_month, month_index,
                                   // years_since_1900, weekday, day_of_year, zero pad

  epdc_result_t expected_dates[$];
  int unsigned  error_count = 0;
  int unsigned  cycle_count = 0;
  bit           tx_idle_en  = 1'b1;
  bit           rx_idle_en  = 1'b1;
  int unsigned  hold_cycles = 0;

  epoch_seconds_to_calendar_date_top i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // free-running clock, 12 ns period
  initial begin
    forever #6 clk = ~clk;
  end

  // gregorian rule on the full calendar year
  function automatic bit gregorian_leap(input int unsigned yr);
    return ((yr % 4) == 0) && (((yr % 100) != 0) || ((yr % 400) == 0));
  endfunction

  function automatic int unsigned month_length(input int unsigned mon, input bit leap);
    return MONTH_LEN[mon] + ((mon == 1 && leap) ? 1 : 0);
  endfunction

  // broken-down utc date for one count of seconds
  function automatic epdc_result_t predict_calendar_date(input logic [31:0] secs);
    epdc_result_t r;
    int unsigned  tod;
    int unsigned  days;
    int unsigned  yr;
    int unsigned  mon;
    bit           leap;
    r    = '0;
    tod  = secs % SECS_PER_DAY;
    days = secs / SECS_PER_DAY;
    r.second  = 6'(tod % 60);
    r.minute  = 6'((tod % 3600) / 60);
    r.hour    = 5'(tod / 3600);
    r.weekday = 3'((days + 4) % 7);
    // strip whole years from 1970 on
    yr = 1970;
    while (days >= (gregorian_leap(yr) ? 366 : 365)) begin
      days -= gregorian_leap(yr) ? 366 : 365;
      yr++;
    end
    r.day_of_year = 9'(days);
    leap = gregorian_leap(yr);
    // then whole months, december takes the rest
    mon = 0;
    while (mon < 11 && days >= month_length(mon, leap)) begin
      days -= month_length(mon, leap);
      mon++;
    end
    r.day_of_month     = 5'(days + 1);
    r.month_index      = 4'(mon);
    r.years_since_1900 = 8'(yr - 1900);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
    error_count++;
  endtask

  // offer one beat after a random gap, record its expected date once taken
  task automatic send_epoch(input logic [31:0] secs);
    int unsigned gap;
    gap = tx_idle_en ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= secs;
    do @(posedge clk); while (!in_tready);
    expected_dates.push_back(predict_calendar_date(secs));
  endtask

  // stop offering and wait for every outstanding result
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (expected_dates.size() != 0);
  endtask

  // receiver: random stalls, or a long hold when one is requested
  initial begin
    int unsigned stall;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (hold_cycles > 0) begin
        out_tready <= 1'b0;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
      end else begin
        stall = rx_idle_en ? $urandom_range(0, 9) : 0;
        if (stall > 0) begin
          out_tready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  // compare each accepted result beat with the oldest expected date
  always @(posedge clk) begin : check_beat
    epdc_result_t got;
    epdc_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[45:0];
      if (expected_dates.size() == 0) begin
        report_mismatch("beat with nothing expected, tdata", out_tdata, 0);
      end else begin
        want = expected_dates.pop_front();
        if (got.second != want.second)
          report_mismatch("second", got.second, want.second);
        if (got.minute != want.minute)
          report_mismatch("minute", got.minute, want.minute);
        if (got.hour != want.hour)
          report_mismatch("hour", got.hour, want.hour);
        if (got.day_of_month != want.day_of_month)
          report_mismatch("day_of_month", got.day_of_month, want.day_of_month);
        if (got.month_index != want.month_index)
          report_mismatch("month_index", got.month_index, want.month_index);
        if (got.years_since_1900 != want.years_since_1900)
          report_mismatch("years_since_1900", got.years_since_1900, want.years_since_1900);
        if (got.weekday != want.weekday)
          report_mismatch("weekday", got.weekday, want.weekday);
        if (got.day_of_year != want.day_of_year)
          report_mismatch("day_of_year", got.day_of_year, want.day_of_year);
        if (out_tdata[47:46] != 2'b00)
          report_mismatch("pad bits", out_tdata[47:46], 0);
      end
    end
  end

  // watchdog on total run length
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // time-of-day rollovers, leap days, century non-leap year, range ends, bit patterns
  task automatic test_calendar_corners();
    logic [31:0] corners [24];
    corners = '{32'd0, 32'd1, 32'd59, 32'd60, 32'd3599, 32'd3600, 32'd86399, 32'd86400,
                32'd31449600, 32'd31536000, 32'd68169600, 32'd94694399, 32'd94694400,
                32'd951782400, 32'd978307199, 32'd4107542399, 32'd4107542400,
                32'd4133980799, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFE,
                32'hFFFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555};
    foreach (corners[i]) send_epoch(corners[i]);
  endtask

  task automatic test_full_range_random();
    repeat (1000) send_epoch($urandom());
  endtask

  // random days at midnight, at the last second, or anywhere within
  task automatic test_day_edges();
    int unsigned day;
    int unsigned pick;
    repeat (500) begin
      day  = $urandom_range(0, LAST_FULL_DAY);
      pick = $urandom_range(0, 2);
      case (pick)
        0:       send_epoch(day * SECS_PER_DAY);
        1:       send_epoch(day * SECS_PER_DAY + SECS_PER_DAY - 1);
        default: send_epoch(day * SECS_PER_DAY + $urandom_range(0, SECS_PER_DAY - 1));
      endcase
    end
  endtask

  // first few years keep the year walk short
  task automatic test_early_years();
    repeat (250) send_epoch($urandom_range(0, 378777600));
  endtask

  // no idling on either side
  task automatic test_back_to_back();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    repeat (200) send_epoch($urandom());
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
  endtask

  // receiver holds off long enough for the input side to stall
  task automatic test_output_hold();
    wait_drained();
    hold_cycles = 600;
    tx_idle_en  = 1'b0;
    repeat (30) send_epoch($urandom());
    tx_idle_en  = 1'b1;
    wait_drained();
  endtask

  // short bursts, each fully drained before the next
  task automatic test_sender_pause();
    repeat (4) begin
      repeat (5) send_epoch($urandom());
      wait_drained();
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    test_calendar_corners();
    test_full_range_random();
    test_day_edges();
    test_early_years();
    test_back_to_back();
    test_output_hold();
    test_sender_pause();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
